FILE: sv/lgsc_pkg.sv
// Shared constants, status codes and the control command type of the group slot cache.
package lgsc_pkg;

  // Geometry of the cache and the request.
  localparam int SLOTS       = 8;
  localparam int GROUP_BITS  = 16;
  localparam int SLOT_BITS   = $clog2(SLOTS);
  localparam int COUNT_BITS  = $clog2(SLOTS + 1);
  localparam int GCOUNT_BITS = GROUP_BITS + 1;
  localparam int STATUS_BITS = 3;

  // Result status codes.
  localparam logic [STATUS_BITS-1:0] ST_HIT   = 3'd0;
  localparam logic [STATUS_BITS-1:0] ST_LOAD  = 3'd1;
  localparam logic [STATUS_BITS-1:0] ST_RANGE = 3'd2;
  localparam logic [STATUS_BITS-1:0] ST_WRONG = 3'd3;
  localparam logic [STATUS_BITS-1:0] ST_FAIL  = 3'd4;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;  // latch the incoming request beat
    logic commit;   // resolve the request, update the list, load the result
  } lgsc_cmd_t;

endpackage

FILE: sv/lgsc_ctrl.sv
// Controller of the group slot cache: request sequencing and output handshake.
module lgsc_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  output lgsc_pkg::lgsc_cmd_t cmd
);
  import lgsc_pkg::*;

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_t;

  state_t state;
  logic   can_commit;

  // The result register is free when empty or being drained this cycle.
  assign can_commit = !out_valid || !out_stall;

  // Commands and input stall follow from the state.
  assign in_stall    = (state == S_EXEC);
  assign cmd.capture = (state == S_IDLE) && in_valid;
  assign cmd.commit  = (state == S_EXEC) && can_commit;

  // State and the output valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            state <= S_EXEC;
          end
          if (out_valid && !out_stall) begin
            out_valid <= 1'b0;
          end
        end
        S_EXEC: begin
          if (can_commit) begin
            state     <= S_IDLE;
            out_valid <= 1'b1;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

FILE: sv/lgsc_dpath.sv
// Datapath of the group slot cache: recency list, tag compare, shift and result registers.
module lgsc_dpath (
  input  logic                                clk,
  input  logic                                rst,
  input  lgsc_pkg::lgsc_cmd_t                 cmd,
  input  logic                                cfg_write,
  input  logic [lgsc_pkg::GCOUNT_BITS-1:0]    cfg_data,
  input  logic [lgsc_pkg::GROUP_BITS-1:0]     group,
  input  logic                                load_fails,
  output logic [lgsc_pkg::STATUS_BITS-1:0]    status,
  output logic [lgsc_pkg::SLOT_BITS-1:0]      buffer_slot,
  output logic                                evict_valid,
  output logic [lgsc_pkg::GROUP_BITS-1:0]     evict_group,
  output logic [lgsc_pkg::SLOT_BITS-1:0]      evict_buffer
);
  import lgsc_pkg::*;

  // Configuration and the captured request.
  logic [GCOUNT_BITS-1:0] group_count;
  logic [GROUP_BITS-1:0]  req_group;
  logic                   req_fails;

  // Recency list: position 0 is the most recently used.
  logic                  tag_valid       [SLOTS];
  logic [GROUP_BITS-1:0] position_tag    [SLOTS];
  logic [SLOT_BITS-1:0]  position_buffer [SLOTS];
  logic [COUNT_BITS-1:0] loaded_count;

  logic                  tag_valid_next       [SLOTS];
  logic [GROUP_BITS-1:0] position_tag_next    [SLOTS];
  logic [SLOT_BITS-1:0]  position_buffer_next [SLOTS];
  logic [COUNT_BITS-1:0] loaded_count_next;

  logic [STATUS_BITS-1:0] status_next;
  logic [SLOT_BITS-1:0]   buffer_slot_next;
  logic                   evict_valid_next;
  logic [GROUP_BITS-1:0]  evict_group_next;
  logic [SLOT_BITS-1:0]   evict_buffer_next;

  logic                  out_of_range;
  logic                  front_hit;
  logic                  direct_mode;
  logic [SLOT_BITS-1:0]  direct_pos;
  logic [SLOTS-1:0]      match;
  logic                  hit_any;
  logic [SLOT_BITS-1:0]  hit_idx;
  logic [COUNT_BITS-1:0] grown_count;
  logic [SLOT_BITS-1:0]  miss_end;
  logic [SLOT_BITS-1:0]  shift_end;
  logic [SLOT_BITS-1:0]  sel_idx;
  logic                  sel_valid;
  logic [GROUP_BITS-1:0] sel_tag;
  logic [SLOT_BITS-1:0]  sel_buffer;
  logic                  shift_en;
  logic                  front_valid;

  // Mode and range decisions on the captured request.
  assign out_of_range = {1'b0, req_group} >= group_count;
  assign front_hit    = tag_valid[0] && (position_tag[0] == req_group);
  assign direct_mode  = group_count <= GCOUNT_BITS'(SLOTS);
  assign direct_pos   = req_group[SLOT_BITS-1:0];

  // Parallel tag compare over the loaded positions.
  always_comb begin
    for (int i = 0; i < SLOTS; i++) begin
      match[i] = tag_valid[i] && (position_tag[i] == req_group)
                 && (COUNT_BITS'(i) < loaded_count);
    end
  end

  // The lowest matching position wins.
  always_comb begin
    hit_idx = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (match[i]) begin
        hit_idx = SLOT_BITS'(i);
      end
    end
  end
  assign hit_any = |match;

  // Last position touched by the move to front.
  assign grown_count = (loaded_count < COUNT_BITS'(SLOTS)) ?
                       loaded_count + COUNT_BITS'(1) : loaded_count;
  assign miss_end    = SLOT_BITS'(grown_count - COUNT_BITS'(1));
  assign shift_end   = hit_any ? hit_idx : miss_end;

  // One shared read port into the list.
  assign sel_idx    = direct_mode ? direct_pos : shift_end;
  assign sel_valid  = tag_valid[sel_idx];
  assign sel_tag    = position_tag[sel_idx];
  assign sel_buffer = position_buffer[sel_idx];

  // Resolve the request and form the next list contents.
  always_comb begin
    tag_valid_next       = tag_valid;
    position_tag_next    = position_tag;
    position_buffer_next = position_buffer;
    loaded_count_next    = loaded_count;
    status_next          = ST_RANGE;
    buffer_slot_next     = '0;
    evict_valid_next     = 1'b0;
    evict_group_next     = '0;
    evict_buffer_next    = '0;
    shift_en             = 1'b0;
    front_valid          = 1'b1;

    priority if (out_of_range) begin
      status_next = ST_RANGE;
    end else if (front_hit) begin
      status_next      = ST_HIT;
      buffer_slot_next = position_buffer[0];
    end else if (direct_mode) begin
      buffer_slot_next = sel_buffer;
      priority if (sel_valid) begin
        status_next = (sel_tag != req_group) ? ST_WRONG : ST_HIT;
      end else if (req_fails) begin
        status_next = ST_FAIL;
      end else begin
        status_next                   = ST_LOAD;
        tag_valid_next[direct_pos]    = 1'b1;
        position_tag_next[direct_pos] = req_group;
      end
    end else if (hit_any) begin
      status_next      = ST_HIT;
      buffer_slot_next = sel_buffer;
      shift_en         = 1'b1;
    end else begin
      loaded_count_next = grown_count;
      buffer_slot_next  = sel_buffer;
      shift_en          = 1'b1;
      front_valid       = !req_fails;
      status_next       = req_fails ? ST_FAIL : ST_LOAD;
      // A full list drops its least recently used entry.
      if ((loaded_count == COUNT_BITS'(SLOTS)) && tag_valid[SLOTS-1]) begin
        evict_valid_next  = 1'b1;
        evict_group_next  = position_tag[SLOTS-1];
        evict_buffer_next = position_buffer[SLOTS-1];
      end
    end

    // Move to front: positions up to shift_end slide down by one.
    if (shift_en) begin
      for (int j = 1; j < SLOTS; j++) begin
        if (SLOT_BITS'(j) <= shift_end) begin
          tag_valid_next[j]       = tag_valid[j-1];
          position_tag_next[j]    = position_tag[j-1];
          position_buffer_next[j] = position_buffer[j-1];
        end
      end
      tag_valid_next[0]       = front_valid;
      position_tag_next[0]    = req_group;
      position_buffer_next[0] = sel_buffer;
    end
  end

  // Control state of the list and the group count register.
  always_ff @(posedge clk) begin
    if (rst) begin
      group_count  <= GCOUNT_BITS'(1);
      loaded_count <= '0;
      for (int i = 0; i < SLOTS; i++) begin
        tag_valid[i]       <= 1'b0;
        position_buffer[i] <= SLOT_BITS'(i);
      end
    end else begin
      if (cfg_write) begin
        group_count <= cfg_data;
      end
      if (cmd.commit) begin
        loaded_count    <= loaded_count_next;
        tag_valid       <= tag_valid_next;
        position_buffer <= position_buffer_next;
      end
    end
  end

  // Payload registers: tags, request and result beat.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_group <= group;
      req_fails <= load_fails;
    end
    if (cmd.commit) begin
      position_tag <= position_tag_next;
      status       <= status_next;
      buffer_slot  <= buffer_slot_next;
      evict_valid  <= evict_valid_next;
      evict_group  <= evict_group_next;
      evict_buffer <= evict_buffer_next;
    end
  end

endmodule

FILE: sv/lru_group_slot_cache.sv
// Top level of the group slot cache with move-to-front LRU replacement.
// Each request beat is first captured; then all eight positions are compared in
// parallel, the list is updated and the result register is loaded. in_stall is
// high while a captured request waits for this; a result held by out_stall delays
// the commit further, but the next request may still be captured while a finished
// result waits. The list is held in flip-flops and ready right after reset, with
// no clearing pass.
// group_count must only be written while no request is in flight.
module lru_group_slot_cache (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_write,
  input  logic [lgsc_pkg::GCOUNT_BITS-1:0]  cfg_data,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [lgsc_pkg::GROUP_BITS-1:0]   group,
  input  logic                              load_fails,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [lgsc_pkg::STATUS_BITS-1:0]  status,
  output logic [lgsc_pkg::SLOT_BITS-1:0]    buffer_slot,
  output logic                              evict_valid,
  output logic [lgsc_pkg::GROUP_BITS-1:0]   evict_group,
  output logic [lgsc_pkg::SLOT_BITS-1:0]    evict_buffer
);
  import lgsc_pkg::*;

  lgsc_cmd_t cmd;

  // Sequencing and handshakes.
  lgsc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  // Recency list and result registers.
  lgsc_dpath u_dpath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .cfg_write    (cfg_write),
    .cfg_data     (cfg_data),
    .group        (group),
    .load_fails   (load_fails),
    .status       (status),
    .buffer_slot  (buffer_slot),
    .evict_valid  (evict_valid),
    .evict_group  (evict_group),
    .evict_buffer (evict_buffer)
  );

endmodule

FILE: sv/lgsc_checker.sv
// Port-level checker for the group slot cache, bound to the top level.
module lgsc_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              in_valid,
  input logic                              in_stall,
  input logic                              out_valid,
  input logic                              out_stall,
  input logic [lgsc_pkg::STATUS_BITS-1:0]  status,
  input logic [lgsc_pkg::SLOT_BITS-1:0]    buffer_slot,
  input logic                              evict_valid,
  input logic [lgsc_pkg::GROUP_BITS-1:0]   evict_group,
  input logic [lgsc_pkg::SLOT_BITS-1:0]    evict_buffer
);
  import lgsc_pkg::*;

  // A stalled result beat holds its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(status) && $stable(buffer_slot)
      && $stable(evict_valid) && $stable(evict_group) && $stable(evict_buffer))
    else $error("result beat changed while stalled");

  // A request is followed by a busy cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("request accepted without a busy cycle");

  // Evictions only come with a miss.
  a_evict_on_miss: assert property (@(posedge clk) disable iff (rst)
    out_valid && evict_valid |-> (status == ST_LOAD) || (status == ST_FAIL))
    else $error("eviction reported without a miss");

  // An out-of-range request reports nothing else.
  a_range_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == ST_RANGE) |-> (buffer_slot == '0) && !evict_valid)
    else $error("out-of-range result carries data");

endmodule

bind lru_group_slot_cache lgsc_checker u_lgsc_checker (.*);
